FILE: rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants for the set associative cache lookup block.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // Storage geometry
  localparam int unsigned NumLines = 256;
  localparam int unsigned LineIdxW = 8;
  localparam int unsigned TagW     = 28;
  localparam int unsigned StampW   = 32;
  localparam int unsigned CountW   = 32;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned WayW     = 7;

  // Parameter defaults
  localparam int unsigned CacheBytesLog2Def = 12;
  localparam int unsigned AddrBitsDef       = 32;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_LINE_SIZE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WAYS      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_POLICY    = 2'd2;

  // Replacement policies (the spare code acts as LRU)
  localparam logic [1:0] POL_RANDOM = 2'd0;
  localparam logic [1:0] POL_LRU    = 2'd1;
  localparam logic [1:0] POL_LFU    = 2'd2;

  localparam logic [31:0] LfsrTaps = 32'h8020_0003;

  // One stored line
  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [StampW-1:0] stamp;
    logic [CountW-1:0] count;
  } line_t;

  typedef struct packed {
    logic                en;
    logic [LineIdxW-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic                en;
    logic [LineIdxW-1:0] addr;
    line_t               data;
  } wr_req_t;

  typedef struct packed {
    logic  valid;
    line_t data;
  } rd_rsp_t;

endpackage

FILE: rtl/sacl_if.sv
// ----------------------------------------------------------------------------
// sacl_if
// Valid/ready channels of the cache lookup: address request, result and
// configuration write.
// ----------------------------------------------------------------------------
interface sacl_req_if import sacl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] addr;
  modport source (output valid, output addr, input ready);
  modport sink   (input valid, input addr, output ready);
endinterface

interface sacl_rsp_if import sacl_pkg::*;;
  logic                valid;
  logic                ready;
  logic                hit;
  logic [LineIdxW-1:0] line_index;
  modport source (output valid, output hit, output line_index, input ready);
  modport sink   (input valid, input hit, input line_index, output ready);
endinterface

interface sacl_cfg_if import sacl_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/sacl_store.sv
// ----------------------------------------------------------------------------
// sacl_store
// Line memory (tag, stamp, use count) with one registered read port and one
// write port, plus the per-line valid flags.
// ----------------------------------------------------------------------------
module sacl_store import sacl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  rd_req_t rd_req_i,
  input  wr_req_t wr_req_i,
  output rd_rsp_t rd_rsp_o
);

  line_t               mem [NumLines];
  logic [NumLines-1:0] valid_q;
  line_t               rdata_q;
  logic                rvalid_q;

  // Line memory with a registered read
  always_ff @(posedge clk_i) begin
    if (wr_req_i.en) begin
      mem[wr_req_i.addr] <= wr_req_i.data;
    end
    if (rd_req_i.en) begin
      rdata_q <= mem[rd_req_i.addr];
    end
  end

  // Valid flags, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_req_i.en) begin
        valid_q[wr_req_i.addr] <= 1'b1;
      end
      if (rd_req_i.en) begin
        rvalid_q <= valid_q[rd_req_i.addr];
      end
    end
  end

  assign rd_rsp_o = '{valid: rvalid_q, data: rdata_q};

endmodule

FILE: rtl/sacl_lookup.sv
// ----------------------------------------------------------------------------
// sacl_lookup
// Request decode, way scan, victim choice, line update and result register.
// ----------------------------------------------------------------------------
module sacl_lookup import sacl_pkg::*; #(
  parameter int unsigned CACHE_BYTES_LOG2 = CacheBytesLog2Def,
  parameter int unsigned ADDR_BITS        = AddrBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  logic [AddrW-1:0]    req_addr_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output logic                rsp_hit_o,
  output logic [LineIdxW-1:0] rsp_line_o,
  input  logic [3:0]          line_size_log2_i,
  input  logic [2:0]          ways_log2_i,
  input  logic [1:0]          policy_i,
  output rd_req_t             rd_req_o,
  output wr_req_t             wr_req_o,
  input  rd_rsp_t             rd_rsp_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  localparam logic [AddrW-1:0] AddrMask =
    (ADDR_BITS >= AddrW) ? '1 : AddrW'((64'd1 << ADDR_BITS) - 64'd1);

  logic [1:0]          state_q, state_d;
  logic [LineIdxW-1:0] base_q, base_d;
  logic [TagW-1:0]     tag_q, tag_d;
  logic [WayW-1:0]     wmask_q, wmask_d;
  logic [WayW:0]       issue_q, issue_d;
  logic                chk_vld_q, chk_vld_d;
  logic [WayW-1:0]     chk_way_q, chk_way_d;
  logic [WayW-1:0]     best_way_q, best_way_d;
  logic [31:0]         best_val_q, best_val_d;
  logic [LineIdxW-1:0] wr_idx_q, wr_idx_d;
  logic                hit_q, hit_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [StampW-1:0]   clock_q, clock_d;
  logic [31:0]         lfsr_q, lfsr_d;
  logic                out_valid_q, out_valid_d;
  logic                out_hit_q, out_hit_d;
  logic [LineIdxW-1:0] out_line_q, out_line_d;

  // Geometry from the configuration
  logic [3:0]          lines_log2;
  logic [2:0]          wl;
  logic [3:0]          sets_log2;
  logic [AddrW-1:0]    addr_m;
  logic [LineIdxW-1:0] set_mask;
  logic [LineIdxW-1:0] set_idx;
  logic [4:0]          tag_shift;

  always_comb begin
    int ll;
    ll = int'(CACHE_BYTES_LOG2) - int'(line_size_log2_i);
    if (ll < 0) ll = 0;
    if (ll > 8) ll = 8;
    lines_log2 = 4'(ll);
    if ({1'b0, ways_log2_i} > lines_log2) begin
      wl = lines_log2[2:0];
    end else begin
      wl = ways_log2_i;
    end
    sets_log2 = lines_log2 - {1'b0, wl};
    addr_m    = req_addr_i & AddrMask;
    set_mask  = LineIdxW'((9'd1 << sets_log2) - 9'd1);
    set_idx   = LineIdxW'(addr_m >> line_size_log2_i) & set_mask;
    tag_shift = {1'b0, line_size_log2_i} + {1'b0, sets_log2};
  end

  // Check of the way read in the previous cycle
  logic [LineIdxW-1:0] chk_idx;
  logic [31:0]         chk_val;
  logic                chk_better;
  logic [WayW-1:0]     min_way;
  logic [31:0]         lfsr_next;
  logic [CountW-1:0]   hit_cnt;

  always_comb begin
    chk_idx    = base_q + LineIdxW'(chk_way_q);
    chk_val    = (policy_i == POL_LFU) ? rd_rsp_i.data.count : rd_rsp_i.data.stamp;
    chk_better = (chk_way_q == '0) || (chk_val < best_val_q);
    min_way    = chk_better ? chk_way_q : best_way_q;
    lfsr_next  = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? LfsrTaps : 32'd0);
    hit_cnt    = (rd_rsp_i.data.count == '1) ? rd_rsp_i.data.count
                                             : rd_rsp_i.data.count + 1'b1;
  end

  // Controller
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    tag_d       = tag_q;
    wmask_d     = wmask_q;
    issue_d     = issue_q;
    chk_vld_d   = 1'b0;
    chk_way_d   = chk_way_q;
    best_way_d  = best_way_q;
    best_val_d  = best_val_q;
    wr_idx_d    = wr_idx_q;
    hit_d       = hit_q;
    cnt_d       = cnt_q;
    clock_d     = clock_q;
    lfsr_d      = lfsr_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    out_hit_d   = out_hit_q;
    out_line_d  = out_line_q;
    rd_req_o    = '{en: 1'b0, addr: base_q + LineIdxW'(issue_q)};
    wr_req_o    = '{en: 1'b0, addr: wr_idx_q,
                    data: '{tag: tag_q, stamp: clock_q + 1'b1, count: cnt_q}};

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          base_d  = LineIdxW'(set_idx << wl);
          tag_d   = TagW'(addr_m >> tag_shift);
          wmask_d = WayW'((8'd1 << wl) - 8'd1);
          issue_d = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue the next way
        if (issue_q <= {1'b0, wmask_q}) begin
          rd_req_o.en = 1'b1;
          chk_vld_d   = 1'b1;
          chk_way_d   = issue_q[WayW-1:0];
          issue_d     = issue_q + 1'b1;
        end
        if (chk_vld_q) begin
          if (!rd_rsp_i.valid) begin
            wr_idx_d  = chk_idx;
            hit_d     = 1'b0;
            cnt_d     = CountW'(1);
            chk_vld_d = 1'b0;
            state_d   = S_WRITE;
          end else if (rd_rsp_i.data.tag == tag_q) begin
            wr_idx_d  = chk_idx;
            hit_d     = 1'b1;
            cnt_d     = hit_cnt;
            chk_vld_d = 1'b0;
            state_d   = S_WRITE;
          end else begin
            best_way_d = min_way;
            best_val_d = chk_better ? chk_val : best_val_q;
            if (chk_way_q == wmask_q) begin
              // Set full: replace a victim
              hit_d     = 1'b0;
              cnt_d     = CountW'(1);
              chk_vld_d = 1'b0;
              state_d   = S_WRITE;
              if (policy_i == POL_RANDOM) begin
                lfsr_d   = lfsr_next;
                wr_idx_d = base_q + LineIdxW'(lfsr_next[WayW-1:0] & wmask_q);
              end else begin
                wr_idx_d = base_q + LineIdxW'(min_way);
              end
            end
          end
        end
      end
      S_WRITE: begin
        if (!out_valid_q || rsp_ready_i) begin
          wr_req_o.en = 1'b1;
          clock_d     = clock_q + 1'b1;
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          out_line_d  = wr_idx_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chk_vld_q   <= 1'b0;
      clock_q     <= '0;
      lfsr_q      <= 32'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_vld_q   <= chk_vld_d;
      clock_q     <= clock_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    tag_q      <= tag_d;
    wmask_q    <= wmask_d;
    issue_q    <= issue_d;
    chk_way_q  <= chk_way_d;
    best_way_q <= best_way_d;
    best_val_q <= best_val_d;
    wr_idx_q   <= wr_idx_d;
    hit_q      <= hit_d;
    cnt_q      <= cnt_d;
    out_hit_q  <= out_hit_d;
    out_line_q <= out_line_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign rsp_hit_o   = out_hit_q;
  assign rsp_line_o  = out_line_q;

endmodule

FILE: rtl/set_assoc_cache_lookup_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup_top
// Set associative cache lookup with random, LRU or LFU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : one byte address per request; the result is one hit flag and
//             the index of the line that was hit or filled, on out_rsp.
//   cfg     : register writes (line size, ways, policy), always ready; write
//             only while the block is idle.
//   Scan    : a request scans the ways of its set in order; the first invalid
//             or matching way ends the scan, a full set scans all ways, up
//             to 128. The line memory is read one way per cycle through its
//             single registered read port.
//   A new request is accepted once the line update is written, while the
//   previous result may still wait in the output register. If the receiver
//   stalls, the next result holds in the update step until it is taken.
//   Reset clears the valid flags at once, the access clock, the LFSR (to
//   one) and the registers (4, 2, 1); no clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup_top import sacl_pkg::*; #(
  parameter int unsigned CACHE_BYTES_LOG2 = CacheBytesLog2Def,
  parameter int unsigned ADDR_BITS        = AddrBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sacl_req_if.sink   in_req,
  sacl_rsp_if.source out_rsp,
  sacl_cfg_if.sink   cfg
);

  logic [3:0] line_size_log2_q;
  logic [2:0] ways_log2_q;
  logic [1:0] policy_q;
  rd_req_t    rd_req;
  wr_req_t    wr_req;
  rd_rsp_t    rd_rsp;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_size_log2_q <= 4'd4;
      ways_log2_q      <= 3'd2;
      policy_q         <= POL_LRU;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_LINE_SIZE: line_size_log2_q <= cfg.data[3:0];
        CFG_WAYS:      ways_log2_q      <= cfg.data[2:0];
        CFG_POLICY:    policy_q         <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  sacl_lookup #(
    .CACHE_BYTES_LOG2 (CACHE_BYTES_LOG2),
    .ADDR_BITS        (ADDR_BITS)
  ) u_lookup (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (in_req.valid),
    .req_ready_o      (in_req.ready),
    .req_addr_i       (in_req.addr),
    .rsp_valid_o      (out_rsp.valid),
    .rsp_ready_i      (out_rsp.ready),
    .rsp_hit_o        (out_rsp.hit),
    .rsp_line_o       (out_rsp.line_index),
    .line_size_log2_i (line_size_log2_q),
    .ways_log2_i      (ways_log2_q),
    .policy_i         (policy_q),
    .rd_req_o         (rd_req),
    .wr_req_o         (wr_req),
    .rd_rsp_i         (rd_rsp)
  );

  sacl_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_req_i (rd_req),
    .wr_req_i (wr_req),
    .rd_rsp_o (rd_rsp)
  );

endmodule

FILE: test/tb_set_assoc_cache_lookup_top.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lookup_top
// Self-checking bench for the cache lookup: a line-state predictor tracks
// tags, stamps and counts under each geometry and policy; results are checked
// in order against the predicted hit flag and line index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_set_assoc_cache_lookup_top;
  import sacl_pkg::*;

  typedef struct packed {
    logic                hit;
    logic [LineIdxW-1:0] line_index;
  } lookup_t;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    logic [AddrW-1:0]    addr;
  } op_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sacl_req_if req_if ();
  sacl_rsp_if rsp_if ();
  sacl_cfg_if cfg_if ();

  set_assoc_cache_lookup_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_req (req_if.sink),
    .out_rsp(rsp_if.source),
    .cfg    (cfg_if.sink)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state
  logic              line_valid [NumLines];
  logic [TagW-1:0]   line_tag   [NumLines];
  logic [StampW-1:0] line_stamp [NumLines];
  logic [CountW-1:0] line_count [NumLines];
  logic [31:0]       clock_ctr;
  logic [31:0]       lfsr;
  logic [3:0]        cur_line_log2;
  logic [2:0]        cur_ways_log2;
  logic [1:0]        cur_policy;

  op_t     pending_ops[$];
  lookup_t expected_lookups[$];
  int      errors = 0;
  int      cycles = 0;
  bit      stim_done = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void apply_cfg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    case (idx)
      CFG_LINE_SIZE: cur_line_log2 = val[3:0];
      CFG_WAYS:      cur_ways_log2 = val[2:0];
      CFG_POLICY:    cur_policy    = val[1:0];
      default: ;
    endcase
  endfunction

  // Stamp and count the touched line, filling it when asked
  function automatic void touch(input int idx, input bit fill, input logic [TagW-1:0] tg);
    clock_ctr++;
    line_stamp[idx] = clock_ctr;
    if (fill) begin
      line_valid[idx] = 1'b1;
      line_tag[idx]   = tg;
      line_count[idx] = 1;
    end else if (line_count[idx] != '1) begin
      line_count[idx]++;
    end
  endfunction

  function automatic lookup_t predict_lookup(input logic [AddrW-1:0] addr);
    int ll, wl, sl, ways, base, setn, victim;
    logic [63:0] sh;
    logic [TagW-1:0] tg;
    lookup_t r;
    ll = int'(CacheBytesLog2Def) - int'(cur_line_log2);
    if (ll < 0) ll = 0;
    if (ll > 8) ll = 8;
    wl = (int'(cur_ways_log2) > ll) ? ll : int'(cur_ways_log2);
    sl = ll - wl;
    ways = 1 << wl;
    sh = {32'd0, addr} >> cur_line_log2;
    setn = int'(sh & ((64'd1 << sl) - 1));
    tg = TagW'(({32'd0, addr} >> (int'(cur_line_log2) + sl)));
    base = setn << wl;
    for (int i = 0; i < ways; i++) begin
      int idx;
      idx = (base + i) & (NumLines - 1);
      if (!line_valid[idx]) begin
        touch(idx, 1'b1, tg);
        r.hit = 1'b0; r.line_index = idx[7:0];
        return r;
      end
      if (line_tag[idx] == tg) begin
        touch(idx, 1'b0, tg);
        r.hit = 1'b1; r.line_index = idx[7:0];
        return r;
      end
    end
    if (cur_policy == POL_RANDOM) begin
      logic lsb;
      lsb = lfsr[0];
      lfsr = lfsr >> 1;
      if (lsb) lfsr ^= LfsrTaps;
      victim = base + int'(lfsr & (ways - 1));
    end else begin
      victim = base;
      for (int i = 1; i < ways; i++) begin
        if (cur_policy == POL_LFU) begin
          if (line_count[base + i] < line_count[victim]) victim = base + i;
        end else begin
          if (line_stamp[base + i] < line_stamp[victim]) victim = base + i;
        end
      end
    end
    victim &= NumLines - 1;
    touch(victim, 1'b1, tg);
    r.hit = 1'b0; r.line_index = victim[7:0];
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Driver: requests and register writes from one queue
  int  req_gap = 0;
  bit  cfg_hold = 1'b0;
  int  hold_cnt = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        expected_lookups.push_back(predict_lookup(req_if.addr));
        pending_ops.pop_front();
      end
      if (cfg_if.valid && cfg_if.ready) begin
        apply_cfg(cfg_if.index, cfg_if.data);
        pending_ops.pop_front();
      end
      if ((req_if.valid && !req_if.ready) || (cfg_if.valid && !cfg_if.ready)) begin
        // keep holding
      end else if (pending_ops.size() == 0) begin
        req_if.valid <= 1'b0;
        cfg_if.valid <= 1'b0;
      end else if (pending_ops[0].is_cfg) begin
        req_if.valid <= 1'b0;
        // wait for idle, then let the block drain its last update
        if (expected_lookups.size() != 0 || (req_if.valid && req_if.ready)) begin
          cfg_if.valid <= 1'b0;
          hold_cnt <= 0;
        end else if (hold_cnt < 140) begin
          cfg_if.valid <= 1'b0;
          hold_cnt <= hold_cnt + 1;
        end else begin
          cfg_if.valid <= 1'b1;
          cfg_if.index <= pending_ops[0].index;
          cfg_if.data  <= pending_ops[0].data;
          hold_cnt <= 0;
        end
      end else if (req_gap > 0) begin
        req_gap <= req_gap - 1;
        req_if.valid <= 1'b0;
        cfg_if.valid <= 1'b0;
      end else begin
        cfg_if.valid <= 1'b0;
        req_if.valid <= 1'b1;
        req_if.addr  <= pending_ops[0].addr;
        req_gap <= gap_len();
      end
    end
  end

  // Monitor with random back-pressure
  int rsp_gap = 0;
  always @(posedge clk_i) begin
    lookup_t e;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_lookups.size() == 0) begin
          report($sformatf("unexpected result hit=%0b line=%0d",
                           rsp_if.hit, rsp_if.line_index));
        end else begin
          e = expected_lookups.pop_front();
          if (rsp_if.hit !== e.hit)
            report($sformatf("hit %0b, expected %0b", rsp_if.hit, e.hit));
          if (rsp_if.line_index !== e.line_index)
            report($sformatf("line %0d, expected %0d", rsp_if.line_index,
                             e.line_index));
        end
      end
      if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rsp_gap <= gap_len();
      end
    end
  end

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input int val);
    op_t o;
    o = '0; o.is_cfg = 1'b1; o.index = idx; o.data = val;
    pending_ops.push_back(o);
  endtask

  task automatic add_lookup(input logic [AddrW-1:0] a);
    op_t o;
    o = '0; o.addr = a;
    pending_ops.push_back(o);
  endtask

  // Random addresses drawn from a small pool of tags so sets fill and hit
  task automatic add_random_phase(input int n);
    logic [AddrW-1:0] pool[8];
    for (int i = 0; i < 8; i++) pool[i] = $urandom();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7)
        add_lookup(pool[$urandom_range(0, 7)] ^ ($urandom_range(0, 3) << 10)
                   ^ $urandom_range(0, 15));
      else
        add_lookup($urandom());
    end
  endtask

  initial begin
    req_if.valid = 1'b0; req_if.addr = '0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    for (int i = 0; i < NumLines; i++) begin
      line_valid[i] = 1'b0; line_tag[i] = '0; line_stamp[i] = '0; line_count[i] = '0;
    end
    clock_ctr = '0; lfsr = 32'd1;
    cur_line_log2 = 4'd4; cur_ways_log2 = 3'd2; cur_policy = POL_LRU;

    // Directed: extremes of the address, hits and fills
    add_lookup(32'h0000_0000);
    add_lookup(32'hFFFF_FFFF);
    add_lookup(32'h0000_0000);
    add_lookup(32'hFFFF_FFFF);
    for (int i = 0; i < 5; i++) add_lookup(32'h0000_0100 * i);
    add_lookup(32'h0000_0100);
    add_lookup(32'hAAAA_AAAA);
    add_lookup(32'h5555_5555);
    // Random policy, largest way setting (128 ways in two sets)
    add_cfg(CFG_POLICY, POL_RANDOM);
    add_cfg(CFG_WAYS, 7);
    for (int i = 0; i < 4; i++) add_lookup($urandom());
    // Spare policy code, LFU, oversized line size
    add_cfg(CFG_POLICY, 3);
    add_cfg(CFG_LINE_SIZE, 15);
    add_lookup(32'h1234_5678); add_lookup(32'h8765_4321); add_lookup(32'h1234_5678);
    add_cfg(CFG_POLICY, POL_LFU);
    add_cfg(CFG_LINE_SIZE, 4);
    add_cfg(CFG_WAYS, 0);
    for (int i = 0; i < 4; i++) add_lookup(32'h0000_1000 * i);

    // Random phases over several settings
    for (int ph = 0; ph < 12; ph++) begin
      add_cfg(CFG_LINE_SIZE, (ph % 4 == 0) ? 8 : (ph % 4 == 1) ? 4 : $urandom_range(0, 15));
      add_cfg(CFG_WAYS, (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 4 : $urandom_range(0, 7));
      add_cfg(CFG_POLICY, ph % 4);
      add_random_phase(80);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_ops.size() == 0);
    wait (expected_lookups.size() == 0);
    repeat (200) @(posedge clk_i);
    stim_done = 1'b1;
  end

  // End of run or timeout
  initial begin
    wait (stim_done || cycles >= 2000000);
    if (stim_done && errors == 0) begin
      $display("** set_assoc_cache_lookup_top: PASSED **");
    end else begin
      $display("** set_assoc_cache_lookup_top: FAILED **");
    end
    $finish;
  end

endmodule
